// File: hw/rtl/mmc_pkg.sv
// Shared types and constants for the magnetometer min/max calibrator.
`timescale 1ns / 1ps

package mmc_pkg;

    // Width of every sample and corrected-axis field on the ports
    localparam int FIELD_W = 16;

    // Quotient bits produced by the divider: 16 result bits plus one for saturation
    localparam int Q_BITS = 17;

    // Saturation limits as quotient magnitudes
    localparam logic [Q_BITS-1:0] LIM_POS = 17'd32767;
    localparam logic [Q_BITS-1:0] LIM_NEG = 17'd32768;

    // Saturated result values
    localparam logic [FIELD_W-1:0] NORM_MAX = 16'h7FFF;
    localparam logic [FIELD_W-1:0] NORM_MIN = 16'h8000;

    // Reset value of the calibration count register
    localparam logic [FIELD_W-1:0] DEFAULT_COUNT = 16'd3000;

    // Result status codes
    typedef enum logic [2:0] {
        ST_VALID = 3'd0,
        ST_UNCAL = 3'd1,
        ST_TAKEN = 3'd2,
        ST_DONE  = 3'd3,
        ST_ZERO  = 3'd4
    } t_status;

    // Divider result toward the controller
    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [Q_BITS-1:0] quo;
    } t_div_res;

endpackage

// File: hw/rtl/mmc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle with overflow detect.
`timescale 1ns / 1ps

module mmc_div #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [SAMPLE_BITS+FRAC_BITS-1:0] i_dividend,
    input  logic [SAMPLE_BITS-1:0]           i_divisor,
    output mmc_pkg::t_div_res                o_res
);
    import mmc_pkg::*;

    localparam int MAG_W = SAMPLE_BITS + FRAC_BITS;
    localparam int DVD_W = MAG_W + Q_BITS;
    localparam int CNT_W = $clog2(Q_BITS + 1);

    logic [DVD_W-1:0]       w_pad;
    logic [MAG_W-1:0]       w_hi;
    logic                   w_ovf;
    logic [SAMPLE_BITS:0]   w_trial;
    logic [SAMPLE_BITS:0]   w_sub;
    logic                   w_ge;
    logic [SAMPLE_BITS-1:0] n_rem;

    logic [SAMPLE_BITS-1:0] r_rem;
    logic [SAMPLE_BITS-1:0] r_dsr;
    logic [Q_BITS-1:0]      r_sh;
    logic                   r_ovf;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_done;

    // Split the dividend: the high part decides overflow and seeds the remainder
    always_comb begin
        w_pad = {{Q_BITS{1'b0}}, i_dividend};
        w_hi  = w_pad[DVD_W-1:Q_BITS];
        w_ovf = (w_hi >= {{FRAC_BITS{1'b0}}, i_divisor});
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_sh[Q_BITS-1]};
        w_sub   = w_trial - {1'b0, r_dsr};
        w_ge    = (w_trial >= {1'b0, r_dsr});
        n_rem   = w_ge ? w_sub[SAMPLE_BITS-1:0] : w_trial[SAMPLE_BITS-1:0];
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(Q_BITS);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_hi[SAMPLE_BITS-1:0];
            r_sh  <= w_pad[Q_BITS-1:0];
            r_dsr <= i_divisor;
            r_ovf <= w_ovf;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[Q_BITS-2:0], w_ge};
        end
    end

    assign o_res = '{done: r_done, ovf: r_ovf, quo: r_sh};

endmodule

// File: hw/rtl/magnetometer_minmax_calibrator_top.sv
// Top level of the magnetometer min/max calibrator with stream ports.
// Calibration request, or a measure answered without division: goes to the finish state,
// which loads the output register once it is free; the next request is taken back in idle.
// Measure request: three axes in turn through one bit-serial divider, each via start and wait;
// the finish state then loads the result, and no new request is taken until idle again.
// The divider's 17 quotient steps per axis set the measure rate.
// Synchronous active-low reset: count 3000, round cleared, not calibrated, output empty.
`timescale 1ns / 1ps

module magnetometer_minmax_calibrator_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: calibration_count
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // raw_x[15:0], raw_y[31:16], raw_z[47:32]
    input  logic        s_axis_tuser,   // func[0]
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // norm_x[15:0], norm_y[31:16], norm_z[47:32]
    output logic [3:0]  m_axis_tuser    // status[2:0], clipped[3]
);
    import mmc_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int MAG_W = SAMPLE_BITS + FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state                   r_state;
    logic [FIELD_W-1:0]       r_cal_count;
    logic [FIELD_W-1:0]       r_seen;
    logic signed [SB-1:0]     r_max  [3];
    logic signed [SB-1:0]     r_min  [3];
    logic signed [SB-1:0]     r_bias [3];
    logic [SB-1:0]            r_hr   [3];
    logic                     r_cal;
    logic signed [SB-1:0]     r_raw  [3];
    logic [1:0]               r_axis;
    logic                     r_neg;
    logic [FIELD_W-1:0]       r_norm [3];
    logic                     r_clip;
    t_status                  r_status;

    logic                     r_m_valid;
    logic [FIELD_W-1:0]       r_m_norm [3];
    logic                     r_m_clip;
    t_status                  r_m_status;

    logic                     w_acc;
    logic                     w_out_free;
    logic signed [SB-1:0]     w_raw  [3];
    logic signed [SB-1:0]     w_nmax [3];
    logic signed [SB-1:0]     w_nmin [3];
    logic signed [SB-1:0]     w_nbias[3];
    logic [SB-1:0]            w_nhr  [3];
    logic signed [SB:0]       w_sum  [3];
    logic signed [SB:0]       w_rnd  [3];
    logic [SB:0]              w_span [3];
    logic                     w_finish;
    logic                     w_zero;
    logic signed [SB:0]       w_diff;
    logic [SB:0]              w_abs;
    logic [MAG_W-1:0]         w_mag;
    t_div_res                 w_div;
    logic [FIELD_W-1:0]       w_q_sat;
    logic                     w_q_clip;

    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // Unpack samples and form the updated extremes, bias and half-range per axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_raw[i]   = s_axis_tdata[FIELD_W*i +: SB];
            w_nmax[i]  = (w_raw[i] > r_max[i]) ? w_raw[i] : r_max[i];
            w_nmin[i]  = (w_raw[i] < r_min[i]) ? w_raw[i] : r_min[i];
            w_sum[i]   = {w_nmax[i][SB-1], w_nmax[i]} + {w_nmin[i][SB-1], w_nmin[i]};
            // round toward zero before halving
            w_rnd[i]   = w_sum[i] + {{SB{1'b0}}, w_sum[i][SB]};
            w_nbias[i] = w_rnd[i][SB:1];
            w_span[i]  = {w_nmax[i][SB-1], w_nmax[i]} - {w_nmin[i][SB-1], w_nmin[i]};
            w_nhr[i]   = w_span[i][SB:1];
        end
        w_finish = ({1'b0, r_seen} + 17'd1) >= {1'b0, r_cal_count};
        w_zero   = (r_hr[0] == '0) || (r_hr[1] == '0) || (r_hr[2] == '0);
    end

    // Offset-corrected magnitude of the current axis, scaled by the fraction bits
    always_comb begin
        w_diff = {r_raw[r_axis][SB-1], r_raw[r_axis]} - {r_bias[r_axis][SB-1], r_bias[r_axis]};
        w_abs  = w_diff[SB] ? (~w_diff + 1'b1) : w_diff;
        w_mag  = {w_abs[SB-1:0], {FRAC_BITS{1'b0}}};
    end

    mmc_div #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_START),
        .i_dividend(w_mag),
        .i_divisor (r_hr[r_axis]),
        .o_res     (w_div)
    );

    // Apply sign and saturate the quotient to the 16-bit result
    always_comb begin
        if (r_neg) begin
            w_q_clip = w_div.ovf || (w_div.quo > LIM_NEG);
            w_q_sat  = w_q_clip ? NORM_MIN : FIELD_W'(~w_div.quo + 1'b1);
        end else begin
            w_q_clip = w_div.ovf || (w_div.quo > LIM_POS);
            w_q_sat  = w_q_clip ? NORM_MAX : w_div.quo[FIELD_W-1:0];
        end
    end

    // Hold the calibration count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_count <= DEFAULT_COUNT;
        end else if (i_cfg_we) begin
            r_cal_count <= i_cfg_wdata;
        end
    end

    // Sequence requests and keep the calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seen   <= '0;
            r_cal    <= 1'b0;
            r_axis   <= '0;
            r_clip   <= 1'b0;
            r_status <= ST_UNCAL;
            for (int i = 0; i < 3; i++) begin
                r_max[i]  <= {1'b1, {(SB-1){1'b0}}};
                r_min[i]  <= {1'b0, {(SB-1){1'b1}}};
                r_bias[i] <= '0;
                r_hr[i]   <= '0;
                r_norm[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_clip <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_norm[i] <= '0;
                        end
                        if (!s_axis_tuser) begin
                            r_state <= S_FIN;
                            if (w_finish) begin
                                // close the round: store results, restart extremes
                                r_status <= ST_DONE;
                                r_cal    <= 1'b1;
                                r_seen   <= '0;
                                for (int i = 0; i < 3; i++) begin
                                    r_bias[i] <= w_nbias[i];
                                    r_hr[i]   <= w_nhr[i];
                                    r_max[i]  <= {1'b1, {(SB-1){1'b0}}};
                                    r_min[i]  <= {1'b0, {(SB-1){1'b1}}};
                                end
                            end else begin
                                r_status <= ST_TAKEN;
                                r_seen   <= r_seen + 1'b1;
                                for (int i = 0; i < 3; i++) begin
                                    r_max[i] <= w_nmax[i];
                                    r_min[i] <= w_nmin[i];
                                end
                            end
                        end else if (!r_cal) begin
                            r_status <= ST_UNCAL;
                            r_state  <= S_FIN;
                        end else if (w_zero) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_FIN;
                        end else begin
                            r_status <= ST_VALID;
                            r_axis   <= '0;
                            r_state  <= S_START;
                            for (int i = 0; i < 3; i++) begin
                                r_raw[i] <= w_raw[i];
                            end
                        end
                    end
                end
                S_START: begin
                    r_neg   <= w_diff[SB];
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_div.done) begin
                        r_norm[r_axis] <= w_q_sat;
                        r_clip         <= r_clip | w_q_clip;
                        if (r_axis == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_START;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_FIN && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            r_m_status <= r_status;
            r_m_clip   <= r_clip;
            for (int i = 0; i < 3; i++) begin
                r_m_norm[i] <= r_norm[i];
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_norm[2], r_m_norm[1], r_m_norm[0]};
    assign m_axis_tuser  = {r_m_clip, r_m_status};

    // Divider finishes only while an axis is being waited for
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_WAIT))
        else $error("divider done outside wait");

    // Only a valid correction runs the divider
    a_wait_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_status == ST_VALID))
        else $error("divider running for a non-valid status");

    // Corrected axes and clip flag are zero unless the status is valid
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status != ST_VALID) |-> (m_axis_tdata == '0 && !r_m_clip))
        else $error("nonzero result fields with non-valid status");

    // A calibration request reaches the finish state right after it is accepted
    a_cal_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !s_axis_tuser) |=> (r_state == S_FIN))
        else $error("calibration request not finished at once");

    // Not calibrated implies no stored half-range
    a_uncal_hr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cal |-> w_zero)
        else $error("half-range set while not calibrated");

endmodule
